// File: rtl/tes_pkg.sv
// types, codes and byte classification for the text encoding sniffer
package tes_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = PtrW + 1;

  localparam logic [15:0] SearchLimitRst = 16'd1000;
  localparam logic [7:0]  BraceLimitRst  = 8'd3;
  localparam logic [15:0] PosMax         = 16'hFFFF;
  localparam logic [7:0]  ParenMax       = 8'hFF;

  localparam logic [0:0] CfgSearchLimit = 1'b0;
  localparam logic [0:0] CfgBraceLimit  = 1'b1;

  localparam logic [2:0] EncNone    = 3'd0;
  localparam logic [2:0] EncUtf16Be = 3'd1;
  localparam logic [2:0] EncUtf16Le = 3'd2;
  localparam logic [2:0] EncUtf32Le = 3'd3;
  localparam logic [2:0] EncUtf32Be = 3'd4;
  localparam logic [2:0] EncUtf8    = 3'd5;
  localparam logic [2:0] EncValue   = 3'd6;

  localparam logic [2:0] MsSeek  = 3'd1;
  localparam logic [2:0] MsParen = 3'd2;
  localparam logic [2:0] MsC     = 3'd3;
  localparam logic [2:0] MsA     = 3'd4;

  localparam logic KindValue   = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef enum logic [3:0] {
    PH_SCAN  = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_DONE  = 4'b0100,
    PH_MARK  = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] match_state;
    logic       paren_seen;
    logic [7:0] paren_count;
  } scan_t;

  typedef struct packed {
    logic       item_kind;
    logic [2:0] encoding_code;
    logic [7:0] value_byte;
    logic       final_item;
  } result_t;

  localparam scan_t ScanRst = '{phase: PH_SCAN, match_state: MsSeek,
                                paren_seen: 1'b0, paren_count: 8'd0};

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
  endfunction

  // one pattern step on a byte whose position lies in the search window when pos_ok
  function automatic scan_t scan_step(scan_t s, logic [7:0] b, logic pos_ok,
                                      logic [7:0] brace_limit);
    scan_t      r;
    logic [2:0] fb;
    r  = s;
    fb = s.paren_seen ? MsParen : MsSeek;
    if (s.phase == PH_SCAN && pos_ok) begin
      if (b == 8'h28) begin
        r.match_state = MsParen;
        r.paren_seen  = 1'b1;
        if (s.paren_count != ParenMax) r.paren_count = s.paren_count + 8'd1;
      end else if (b == 8'h43) begin
        r.match_state = (s.match_state == MsParen) ? MsC : fb;
      end else if (b == 8'h41) begin
        r.match_state = (s.match_state == MsC) ? MsA : fb;
      end else if (b == 8'h5B) begin
        if (s.match_state == MsA) begin
          r.phase = (s.paren_count >= brace_limit) ? PH_DONE : PH_VALUE;
        end else begin
          r.match_state = fb;
        end
      end else if (b inside {[8'h41:8'h5A]}) begin
        r.match_state = fb;
      end else if (is_space(b)) begin
        if (s.match_state != MsA) r.match_state = fb;
      end else if (!(b inside {[8'h61:8'h7A]})) begin
        r.match_state = fb;
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] mark_code(logic [7:0] b0, logic [7:0] b1,
                                           logic [7:0] b2, logic [7:0] b3);
    logic [2:0] c;
    c = EncNone;
    if (b0 == 8'hFE && b1 == 8'hFF) begin
      c = EncUtf16Be;
    end else if (b0 == 8'hFF && b1 == 8'hFE) begin
      c = (b2 == 8'h00 && b3 == 8'h00) ? EncUtf32Le : EncUtf16Le;
    end else if (b0 == 8'h00 && b1 == 8'h00 && b2 == 8'hFE && b3 == 8'hFF) begin
      c = EncUtf32Be;
    end else if (b0 == 8'hEF && b1 == 8'hBB && b2 == 8'hBF) begin
      c = EncUtf8;
    end
    return c;
  endfunction

endpackage

// File: rtl/tes_if.sv
// input and output word channels of the text encoding sniffer
interface tes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;
  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tes_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [2:0] encoding_code;
  logic [7:0] value_byte;
  logic       final_item;
  modport source (output valid, output item_kind, output encoding_code,
                  output value_byte, output final_item, input ready);
  modport sink (input valid, input item_kind, input encoding_code,
                input value_byte, input final_item, output ready);
endinterface

// File: rtl/text_encoding_sniffer.sv
// text encoding sniffer: byte order mark and CA[ property detection
// a result word is registered into the output queue when its input word is taken
// throughput: one input word per cycle while the output queue has room; a final word yields up to two result words
// input is taken while the four-word output queue has room for two words
// rst_ni clears position, value and scan state (not the header bytes), the queue and restores search and brace limits
module text_encoding_sniffer
  import tes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tes_in_if.sink      in_i,
  tes_out_if.source   out_o
);

  logic [15:0] search_limit_q;
  logic [7:0]  brace_limit_q;
  logic [15:0] pos_q, pos_d;
  logic        val_seen_q, val_seen_d;
  scan_t       scan_q, scan_d;
  logic [7:0]  head_q [3];

  result_t        fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  logic       accept, pop;
  logic [7:0] b;
  logic       emit_val;
  logic [2:0] verdict;
  logic [2:0] mc;
  scan_t      s0, s1, s2, s3;
  logic [CntW-1:0] n_push;

  assign b      = in_i.data_byte;
  assign accept = in_i.valid && in_i.ready;
  assign pop    = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q <= CntW'(FifoDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_limit_q <= SearchLimitRst;
      brace_limit_q  <= BraceLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSearchLimit: search_limit_q <= cfg_data_i;
        CfgBraceLimit:  brace_limit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign mc = mark_code(head_q[0], head_q[1], head_q[2], b);
  assign s0 = scan_step(scan_q, head_q[0], search_limit_q > 16'd0, brace_limit_q);
  assign s1 = scan_step(s0, head_q[1], search_limit_q > 16'd1, brace_limit_q);
  assign s2 = scan_step(s1, head_q[2], search_limit_q > 16'd2, brace_limit_q);
  assign s3 = scan_step(s2, b, search_limit_q > 16'd3, brace_limit_q);

  always_comb begin
    scan_d     = scan_q;
    val_seen_d = val_seen_q;
    emit_val   = 1'b0;
    verdict    = EncNone;
    pos_d      = (pos_q != PosMax) ? pos_q + 16'd1 : pos_q;
    if (pos_q == 16'd3) begin
      if (mc != EncNone) begin
        scan_d.phase       = PH_MARK;
        scan_d.match_state = mc;
      end else begin
        scan_d = s3;
      end
    end else if (pos_q > 16'd3) begin
      if (scan_q.phase == PH_SCAN) begin
        scan_d = scan_step(scan_q, b, pos_q < search_limit_q, brace_limit_q);
      end else if (scan_q.phase == PH_VALUE) begin
        if (pos_q >= search_limit_q || b == 8'h5D) begin
          scan_d.phase = PH_DONE;
        end else begin
          emit_val   = 1'b1;
          val_seen_d = 1'b1;
        end
      end
    end
    if (pos_q >= 16'd3) begin
      if (scan_d.phase == PH_MARK) verdict = scan_d.match_state;
      else if (val_seen_d)         verdict = EncValue;
    end
    if (in_i.end_of_buffer) begin
      scan_d     = ScanRst;
      val_seen_d = 1'b0;
      pos_d      = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 16'd0;
      val_seen_q <= 1'b0;
      scan_q     <= ScanRst;
    end else if (accept) begin
      pos_q      <= pos_d;
      val_seen_q <= val_seen_d;
      scan_q     <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_q < 16'd3) head_q[pos_q[1:0]] <= b;
  end

  // output queue
  assign n_push = accept ? CntW'(emit_val) + CntW'(in_i.end_of_buffer) : '0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (emit_val) begin
        fifo_q[wr_ptr_q] <= '{item_kind: KindValue, encoding_code: EncValue,
                              value_byte: b, final_item: 1'b0};
        if (in_i.end_of_buffer)
          fifo_q[wr_ptr_q + PtrW'(1)] <= '{item_kind: KindVerdict,
                                           encoding_code: verdict,
                                           value_byte: 8'd0, final_item: 1'b1};
      end else if (in_i.end_of_buffer) begin
        fifo_q[wr_ptr_q] <= '{item_kind: KindVerdict, encoding_code: verdict,
                              value_byte: 8'd0, final_item: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push[PtrW-1:0];
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      cnt_q <= cnt_q + n_push - CntW'(pop);
    end
  end

  assign out_o.valid         = (cnt_q != '0);
  assign out_o.item_kind     = fifo_q[rd_ptr_q].item_kind;
  assign out_o.encoding_code = fifo_q[rd_ptr_q].encoding_code;
  assign out_o.value_byte    = fifo_q[rd_ptr_q].value_byte;
  assign out_o.final_item    = fifo_q[rd_ptr_q].final_item;

endmodule
